// ===== hw/rtl/drc_pkg.sv =====
package drc_pkg;

	localparam int unsigned SPEED_W = 8;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DIR_W   = 4;

	localparam logic [SPEED_W-1:0] SPEED_MAX           = 8'd255;
	localparam logic [SPEED_W-1:0] RESET_DEFAULT_SPEED = 8'd125;
	localparam logic [SPEED_W-1:0] RESET_ACCEL         = 8'd8;
	localparam logic [SPEED_W-1:0] RESET_DECEL         = 8'd12;
	localparam logic [TIME_W-1:0]  RESET_TIMEOUT       = 32'd1000;

	// item kinds
	localparam logic [1:0] CMD_MESSAGE  = 2'd0;
	localparam logic [1:0] CMD_TICK     = 2'd1;
	localparam logic [1:0] CMD_WATCHDOG = 2'd2;
	localparam logic [1:0] CMD_NONE     = 2'd3;

	// message codes
	localparam logic [7:0] MSG_BACK      = 8'd2;
	localparam logic [7:0] MSG_LEFT      = 8'd4;
	localparam logic [7:0] MSG_STOP      = 8'd5;
	localparam logic [7:0] MSG_RIGHT     = 8'd6;
	localparam logic [7:0] MSG_ROT_LEFT  = 8'd7;
	localparam logic [7:0] MSG_FWD       = 8'd8;
	localparam logic [7:0] MSG_ROT_RIGHT = 8'd9;
	localparam logic [7:0] MSG_SET_SPEED = 8'd10;
	localparam logic [7:0] MSG_RESTART   = 8'd66;

	// register indexes
	localparam logic [1:0] REG_ACCEL   = 2'd0;
	localparam logic [1:0] REG_DECEL   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_UNUSED  = 2'd3;

	typedef enum logic [2:0] {
		MOT_STOP      = 3'd0,
		MOT_FWD       = 3'd1,
		MOT_BACK      = 3'd2,
		MOT_LEFT      = 3'd3,
		MOT_RIGHT     = 3'd4,
		MOT_ROT_LEFT  = 3'd5,
		MOT_ROT_RIGHT = 3'd6
	} motion_t;

	typedef struct packed {
		logic [SPEED_W-1:0] accel_step;
		logic [SPEED_W-1:0] decel_step;
		logic [TIME_W-1:0]  silence_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [7:0]         msg_code;
		logic               speed_present;
		logic [31:0]        speed_value;
		logic [TIME_W-1:0]  now_ms;
	} item_t;

	typedef struct packed {
		logic [DIR_W-1:0]   wheel_dirs;
		logic [SPEED_W-1:0] pwm_duty;
		logic [2:0]         active_motion;
		logic               activity_led;
		logic               restart_request;
		logic               unknown_message;
	} result_t;

	function automatic logic [DIR_W-1:0] motion_pattern(input motion_t m);
		logic [DIR_W-1:0] p;
		unique case (m)
			MOT_FWD:       p = 4'hF;
			MOT_LEFT:      p = 4'h5;
			MOT_RIGHT:     p = 4'hA;
			MOT_ROT_LEFT:  p = 4'h9;
			MOT_ROT_RIGHT: p = 4'h6;
			default:       p = 4'h0;
		endcase
		return p;
	endfunction

endpackage

// ===== hw/rtl/drive_command_ramp_controller.sv =====
// path: a request accepted into the input register moves on to the result
//   register and shows on m_tdata, unless a held result stalls it in stage 1
// throughput: one request per cycle while the result register drains; the state
//   update is one pass of logic between the input register and the result register
// stalls: a held result blocks new requests only once stage 1 is full too
// reset: arst_n clears the valid bits of both stages, the controller state
//   and the configuration registers to their reset values at once
module drive_command_ramp_controller
	import drc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// bits: msg_code[7:0], speed_present[8], speed_value[40:9], now_ms[72:41]
	input  logic [79:0] s_tdata,
	// bits: command[1:0]
	input  logic [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// bits: wheel_dirs[3:0], pwm_duty[11:4], active_motion[14:12],
	//   activity_led[15], restart_request[16], unknown_message[17]
	output logic [23:0] m_tdata,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	drc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command       <= s_tuser;
			item_s1.msg_code      <= s_tdata[7:0];
			item_s1.speed_present <= s_tdata[8];
			item_s1.speed_value   <= s_tdata[40:9];
			item_s1.now_ms        <= s_tdata[72:41];
		end
	end

	// state update commits when the request leaves stage 1
	drc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.step_en (advance),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.unknown_message, res_s2.restart_request,
		res_s2.activity_led, res_s2.active_motion, res_s2.pwm_duty, res_s2.wheel_dirs};

	// a stalled result with a full stage 1 must block new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("request taken while both stages stalled");

	// speed can only be nonzero while a motion is active
	a_stop_no_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.active_motion == MOT_STOP) |-> (res_s2.pwm_duty == '0))
		else $error("duty nonzero while stopped");

	// an unknown message still counts as activity
	a_unknown_led: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.unknown_message) |-> res_s2.activity_led)
		else $error("unknown message without activity indication");

	// a result appears the cycle after stage 1 hands over
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result register not loaded");

endmodule

// ===== hw/rtl/drc_cfg_regs.sv =====
module drc_cfg_regs
	import drc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_step         <= RESET_ACCEL;
			cfg_q.decel_step         <= RESET_DECEL;
			cfg_q.silence_timeout_ms <= RESET_TIMEOUT;
		end else if (wr_en) begin
			unique case (idx)
				REG_ACCEL:   cfg_q.accel_step         <= pwdata[SPEED_W-1:0];
				REG_DECEL:   cfg_q.decel_step         <= pwdata[SPEED_W-1:0];
				REG_TIMEOUT: cfg_q.silence_timeout_ms <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ACCEL:   prdata = {24'd0, cfg_q.accel_step};
			REG_DECEL:   prdata = {24'd0, cfg_q.decel_step};
			REG_TIMEOUT: prdata = cfg_q.silence_timeout_ms;
			default:     prdata = 32'd0;
		endcase
	end

endmodule

// ===== hw/rtl/drc_core.sv =====
module drc_core
	import drc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    step_en,
	output result_t res
);

	typedef struct packed {
		motion_t            req_motion;
		motion_t            cur_motion;
		logic [SPEED_W-1:0] req_speed;
		logic [SPEED_W-1:0] cur_speed;
		logic [SPEED_W-1:0] def_speed;
		logic [TIME_W-1:0]  last_time;
		logic               led;
		logic [DIR_W-1:0]   dirs;
	} state_t;

	state_t             st_q;
	state_t             nxt;
	logic [SPEED_W-1:0] msg_speed;
	logic               restart;
	logic               unknown;
	motion_t            cm;
	logic [SPEED_W-1:0] target;
	logic [SPEED_W:0]   up_sum;
	logic [SPEED_W:0]   dn_lim;
	logic [TIME_W-1:0]  elapsed;

	always_comb begin
		nxt       = st_q;
		restart   = 1'b0;
		unknown   = 1'b0;
		cm        = st_q.cur_motion;
		target    = '0;
		// saturate carried speed word
		msg_speed = st_q.def_speed;
		if (item.speed_present)
			msg_speed = (|item.speed_value[31:SPEED_W]) ? SPEED_MAX
				: item.speed_value[SPEED_W-1:0];
		up_sum  = {1'b0, st_q.cur_speed} + {1'b0, cfg.accel_step};
		dn_lim  = '0;
		elapsed = item.now_ms - st_q.last_time;

		unique case (item.command)
			CMD_MESSAGE: begin
				unique case (item.msg_code)
					MSG_RESTART: restart = 1'b1;
					MSG_FWD: begin
						nxt.req_motion = MOT_FWD;
						nxt.req_speed  = msg_speed;
					end
					MSG_BACK: begin
						nxt.req_motion = MOT_BACK;
						nxt.req_speed  = msg_speed;
					end
					MSG_LEFT: begin
						nxt.req_motion = MOT_LEFT;
						nxt.req_speed  = msg_speed;
					end
					MSG_STOP: begin
						nxt.req_motion = MOT_STOP;
						nxt.req_speed  = '0;
					end
					MSG_RIGHT: begin
						nxt.req_motion = MOT_RIGHT;
						nxt.req_speed  = msg_speed;
					end
					MSG_ROT_LEFT: begin
						nxt.req_motion = MOT_ROT_LEFT;
						nxt.req_speed  = msg_speed;
					end
					MSG_ROT_RIGHT: begin
						nxt.req_motion = MOT_ROT_RIGHT;
						nxt.req_speed  = msg_speed;
					end
					MSG_SET_SPEED: begin
						nxt.def_speed = msg_speed;
						if (st_q.req_motion != MOT_STOP)
							nxt.req_speed = msg_speed;
					end
					default: unknown = 1'b1;
				endcase
				if (!restart) begin
					nxt.last_time = item.now_ms;
					nxt.led       = 1'b1;
				end
			end
			CMD_TICK: begin
				// motion changes only at standstill
				if (st_q.cur_motion != st_q.req_motion && st_q.cur_speed == '0) begin
					cm = st_q.req_motion;
					if (cm != MOT_STOP)
						nxt.dirs = motion_pattern(cm);
				end
				nxt.cur_motion = cm;
				if (cm == st_q.req_motion)
					target = st_q.req_speed;
				dn_lim = {1'b0, target} + {1'b0, cfg.decel_step};
				if (st_q.cur_speed < target) begin
					nxt.cur_speed = (up_sum > {1'b0, target}) ? target
						: up_sum[SPEED_W-1:0];
				end else if (st_q.cur_speed > target) begin
					nxt.cur_speed = ({1'b0, st_q.cur_speed} < dn_lim) ? target
						: st_q.cur_speed - cfg.decel_step;
				end
			end
			CMD_WATCHDOG: begin
				if (elapsed > cfg.silence_timeout_ms) begin
					nxt.led        = 1'b0;
					nxt.last_time  = item.now_ms;
					nxt.req_motion = MOT_STOP;
					nxt.req_speed  = '0;
				end
			end
			default: ;
		endcase

		res.wheel_dirs      = nxt.dirs;
		res.pwm_duty        = nxt.cur_speed;
		res.active_motion   = nxt.cur_motion;
		res.activity_led    = nxt.led;
		res.restart_request = restart;
		res.unknown_message = unknown;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.req_motion <= MOT_STOP;
			st_q.cur_motion <= MOT_STOP;
			st_q.req_speed  <= '0;
			st_q.cur_speed  <= '0;
			st_q.def_speed  <= RESET_DEFAULT_SPEED;
			st_q.last_time  <= '0;
			st_q.led        <= 1'b0;
			st_q.dirs       <= '0;
		end else if (step_en) begin
			st_q <= nxt;
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench
	import drc_pkg::*;
();

	// the limit leaves a wide margin over the slowest honest run
	localparam int unsigned CYCLE_LIMIT = 400000;
	// a result passes the input register, then the result register, after its
	// acceptance; the drain waits past that
	localparam int unsigned DRAIN_CYCLES = 4;

	typedef struct {
		item_t   req;
		bit      typed;
		result_t want;
	} directed_row_t;

	// every input starts from a known value
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// bits: msg_code[7:0], speed_present[8], speed_value[40:9], now_ms[72:41]
	logic [79:0] s_tdata  = '0;
	// bits: command[1:0]
	logic [1:0]  s_tuser  = CMD_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// bits: wheel_dirs[3:0], pwm_duty[11:4], active_motion[14:12],
	//   activity_led[15], restart_request[16], unknown_message[17]
	logic [23:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	drive_command_ramp_controller uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// controller state as the testbench tracks it
	cfg_t        cfg_model;
	motion_t     want_motion;
	motion_t     run_motion;
	logic [7:0]  want_speed;
	logic [7:0]  run_speed;
	logic [7:0]  dflt_speed;
	logic [31:0] last_msg_ms;
	logic        led_on;
	logic [3:0]  dirs_latched;

	result_t       pending_status[$];
	directed_row_t directed_rows[$];
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count    = 0;
	bit            gaps_off       = 1'b0;
	logic [31:0]   sim_ms         = '0;

	// a stop request always carries speed zero
	function automatic void set_target(input motion_t m, input logic [7:0] spd);
		want_motion = m;
		want_speed  = (m == MOT_STOP) ? 8'd0 : spd;
	endfunction

	// applies one request to the tracked state and returns the status it should produce
	function automatic result_t advance_controller(input item_t it);
		result_t     r;
		logic [7:0]  spd;
		logic [31:0] elapsed;
		int          goal;
		int          sum;
		r = '0;
		case (it.command)
			CMD_MESSAGE: begin
				spd = dflt_speed;
				if (it.speed_present)
					spd = (it.speed_value > 32'd255) ? SPEED_MAX : it.speed_value[7:0];
				if (it.msg_code == MSG_RESTART) begin
					// restart only raises its flag, nothing else moves
					r.restart_request = 1'b1;
				end else begin
					case (it.msg_code)
						MSG_FWD:       set_target(MOT_FWD, spd);
						MSG_BACK:      set_target(MOT_BACK, spd);
						MSG_LEFT:      set_target(MOT_LEFT, spd);
						MSG_STOP:      set_target(MOT_STOP, 8'd0);
						MSG_RIGHT:     set_target(MOT_RIGHT, spd);
						MSG_ROT_LEFT:  set_target(MOT_ROT_LEFT, spd);
						MSG_ROT_RIGHT: set_target(MOT_ROT_RIGHT, spd);
						MSG_SET_SPEED: begin
							dflt_speed = spd;
							if (want_motion != MOT_STOP)
								want_speed = spd;
						end
						default: r.unknown_message = 1'b1;
					endcase
					// unknown codes still count as activity
					last_msg_ms = it.now_ms;
					led_on      = 1'b1;
				end
			end
			CMD_TICK: begin
				// direction changes only once the wheels are at rest
				if (run_motion != want_motion && run_speed == 8'd0) begin
					run_motion = want_motion;
					case (run_motion)
						MOT_FWD:       dirs_latched = 4'hF;
						MOT_BACK:      dirs_latched = 4'h0;
						MOT_LEFT:      dirs_latched = 4'h5;
						MOT_RIGHT:     dirs_latched = 4'hA;
						MOT_ROT_LEFT:  dirs_latched = 4'h9;
						MOT_ROT_RIGHT: dirs_latched = 4'h6;
						default: ; // stop keeps the last pattern
					endcase
				end
				goal = (run_motion == want_motion) ? int'(want_speed) : 0;
				if (int'(run_speed) < goal) begin
					sum       = int'(run_speed) + int'(cfg_model.accel_step);
					run_speed = (sum > goal) ? goal[7:0] : sum[7:0];
				end else if (int'(run_speed) > goal) begin
					if (int'(run_speed) < goal + int'(cfg_model.decel_step))
						run_speed = goal[7:0];
					else
						run_speed = run_speed - cfg_model.decel_step;
				end
			end
			CMD_WATCHDOG: begin
				// elapsed time wraps modulo 2^32
				elapsed = it.now_ms - last_msg_ms;
				if (elapsed > cfg_model.silence_timeout_ms) begin
					led_on      = 1'b0;
					last_msg_ms = it.now_ms;
					set_target(MOT_STOP, 8'd0);
				end
			end
			default: ; // empty command, status only
		endcase
		r.wheel_dirs    = dirs_latched;
		r.pwm_duty      = run_speed;
		r.active_motion = run_motion;
		r.activity_led  = led_on;
		return r;
	endfunction

	// one request on the input stream, with random idle cycles ahead of it
	task automatic send_request(input item_t it, input bit typed, input result_t want);
		result_t r;
		while (!gaps_off && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.command;
		s_tdata  <= {7'd0, it.now_ms, it.speed_value, it.speed_present, it.msg_code};
		do @(posedge clk); while (!s_tready);
		// predictor always runs so its state stays in step with the block
		r = advance_controller(it);
		pending_status.push_back(typed ? want : r);
	endtask

	// stream goes quiet, every status comes back, then the pipeline drains
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup cycle, then access cycle; the write lands when pready is seen high
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ACCEL:   cfg_model.accel_step         = val[7:0];
			REG_DECEL:   cfg_model.decel_step         = val[7:0];
			REG_TIMEOUT: cfg_model.silence_timeout_ms = val;
			default: ;
		endcase
	endtask

	task automatic add_row(input logic [1:0] cmd, input logic [7:0] code, input logic present,
		input logic [31:0] word, input logic [31:0] stamp, input bit typed, input result_t want);
		directed_row_t row;
		row.req.command       = cmd;
		row.req.msg_code      = code;
		row.req.speed_present = present;
		row.req.speed_value   = word;
		row.req.now_ms        = stamp;
		row.typed             = typed;
		row.want              = want;
		directed_rows.push_back(row);
	endtask

	// motion message with random payload, mostly known codes
	function automatic item_t make_message();
		item_t it;
		int    roll;
		it.command       = CMD_MESSAGE;
		it.speed_present = 1'($urandom_range(0, 1));
		it.now_ms        = sim_ms;
		roll = $urandom_range(0, 2);
		if (roll == 0)
			it.speed_value = $urandom();
		else if (roll == 1)
			it.speed_value = $urandom_range(0, 255);
		else
			it.speed_value = $urandom_range(250, 300);
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			case ($urandom_range(0, 6))
				0:       it.msg_code = MSG_FWD;
				1:       it.msg_code = MSG_BACK;
				2:       it.msg_code = MSG_LEFT;
				3:       it.msg_code = MSG_STOP;
				4:       it.msg_code = MSG_RIGHT;
				5:       it.msg_code = MSG_ROT_LEFT;
				default: it.msg_code = MSG_ROT_RIGHT;
			endcase
		end else if (roll < 85) begin
			it.msg_code = MSG_SET_SPEED;
		end else if (roll < 90) begin
			it.msg_code = MSG_RESTART;
		end else begin
			it.msg_code = 8'($urandom_range(0, 255));
		end
		return it;
	endfunction

	// bursts: one message, then a run of ticks to carry out the ramp,
	// sprinkled with watchdog checks and empty commands
	task automatic run_random(input int count);
		item_t it;
		int    ticks_left;
		int    roll;
		ticks_left = 0;
		for (int i = 0; i < count; i++) begin
			gaps_off = (i >= 40 && i < 100);
			if ($urandom_range(0, 49) == 0)
				sim_ms = $urandom();
			else
				sim_ms = sim_ms + $urandom_range(0, 20);
			if (ticks_left == 0) begin
				it         = make_message();
				ticks_left = $urandom_range(0, 30);
			end else begin
				it.msg_code      = 8'($urandom_range(0, 255));
				it.speed_present = 1'($urandom_range(0, 1));
				it.speed_value   = $urandom();
				roll = $urandom_range(0, 99);
				if (roll < 85) begin
					it.command = CMD_TICK;
				end else if (roll < 95) begin
					it.command = CMD_WATCHDOG;
					// sometimes a long silence to trip the watchdog
					if ($urandom_range(0, 2) == 0)
						sim_ms = sim_ms + $urandom_range(0, 3000);
				end else begin
					it.command = CMD_NONE;
				end
				it.now_ms  = sim_ms;
				ticks_left = ticks_left - 1;
			end
			send_request(it, 1'b0, '0);
		end
		gaps_off = 1'b0;
	endtask

	task automatic compare_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// result checker and receiver stall in one place
	always @(posedge clk) begin : result_check
		result_t seen;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.wheel_dirs      = m_tdata[3:0];
			seen.pwm_duty        = m_tdata[11:4];
			seen.active_motion   = m_tdata[14:12];
			seen.activity_led    = m_tdata[15];
			seen.restart_request = m_tdata[16];
			seen.unknown_message = m_tdata[17];
			if (pending_status.size() == 0) begin
				$display("%0t: status with no request waiting, expected none, actual %h",
					$time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_status.pop_front();
				compare_field("wheel_dirs", 8'(want.wheel_dirs), 8'(seen.wheel_dirs));
				compare_field("pwm_duty", want.pwm_duty, seen.pwm_duty);
				compare_field("active_motion", 8'(want.active_motion),
					8'(seen.active_motion));
				compare_field("activity_led", 8'(want.activity_led), 8'(seen.activity_led));
				compare_field("restart_request", 8'(want.restart_request),
					8'(seen.restart_request));
				compare_field("unknown_message", 8'(want.unknown_message),
					8'(seen.unknown_message));
			end
		end
		m_tready <= arst_n && (gaps_off || $urandom_range(0, 99) >= 25);
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		// tracked state starts at the reset values
		cfg_model.accel_step         = RESET_ACCEL;
		cfg_model.decel_step         = RESET_DECEL;
		cfg_model.silence_timeout_ms = RESET_TIMEOUT;
		want_motion  = MOT_STOP;
		run_motion   = MOT_STOP;
		want_speed   = 8'd0;
		run_speed    = 8'd0;
		dflt_speed   = RESET_DEFAULT_SPEED;
		last_msg_ms  = '0;
		led_on       = 1'b0;
		dirs_latched = 4'h0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: everything quiet after reset
		add_row(CMD_TICK, 8'd0, 1'b0, 32'd0, 32'd0, 1'b1, '{4'h0, 8'd0, 3'd0, 1'b0, 1'b0, 1'b0});
		add_row(CMD_NONE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{4'h0, 8'd0, 3'd0, 1'b0, 1'b0, 1'b0});
		add_row(CMD_WATCHDOG, 8'd0, 1'b0, 32'd0, 32'd0, 1'b1,
			'{4'h0, 8'd0, 3'd0, 1'b0, 1'b0, 1'b0});
		// unknown code lights the led and raises its flag
		add_row(CMD_MESSAGE, 8'd0, 1'b1, 32'd0, 32'd5, 1'b1,
			'{4'h0, 8'd0, 3'd0, 1'b1, 1'b0, 1'b1});
		// restart raises only its own flag
		add_row(CMD_MESSAGE, MSG_RESTART, 1'b0, 32'd0, 32'd6, 1'b1,
			'{4'h0, 8'd0, 3'd0, 1'b1, 1'b1, 1'b0});
		add_row(CMD_MESSAGE, 8'hFF, 1'b0, 32'd0, 32'd7, 1'b1,
			'{4'h0, 8'd0, 3'd0, 1'b1, 1'b0, 1'b1});
		// forward with a speed word far above the clamp
		add_row(CMD_MESSAGE, MSG_FWD, 1'b1, 32'hFFFF_FFFF, 32'd8, 1'b0, '0);
		repeat (3) add_row(CMD_TICK, 8'd0, 1'b0, 32'd0, 32'd9, 1'b0, '0);
		// set-speed without a speed word puts the default speed into the running target
		add_row(CMD_MESSAGE, MSG_SET_SPEED, 1'b0, 32'd0, 32'd20, 1'b0, '0);
		add_row(CMD_TICK, 8'd0, 1'b0, 32'd0, 32'd21, 1'b0, '0);
		// reverse: ramp down to zero before the direction flips
		add_row(CMD_MESSAGE, MSG_BACK, 1'b0, 32'd0, 32'd30, 1'b0, '0);
		repeat (4) add_row(CMD_TICK, 8'd0, 1'b0, 32'd0, 32'd31, 1'b0, '0);
		add_row(CMD_MESSAGE, MSG_LEFT, 1'b1, 32'd256, 32'd40, 1'b0, '0);
		add_row(CMD_TICK, 8'd0, 1'b0, 32'd0, 32'd41, 1'b0, '0);
		// zero speed word on a motion request
		add_row(CMD_MESSAGE, MSG_RIGHT, 1'b1, 32'd0, 32'd42, 1'b0, '0);
		add_row(CMD_MESSAGE, MSG_ROT_LEFT, 1'b1, 32'd255, 32'd43, 1'b0, '0);
		add_row(CMD_MESSAGE, MSG_ROT_RIGHT, 1'b1, 32'd1, 32'd44, 1'b0, '0);
		add_row(CMD_MESSAGE, MSG_STOP, 1'b1, 32'd200, 32'd60, 1'b0, '0);
		// long silence at the top of the time range trips the watchdog
		add_row(CMD_WATCHDOG, 8'd0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0);
		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		run_random(200);
		settle();

		// fastest ramps, watchdog trips on any gap
		write_reg(REG_ACCEL, 32'd255);
		write_reg(REG_DECEL, 32'd255);
		write_reg(REG_TIMEOUT, 32'd0);
		run_random(200);
		settle();

		// slowest ramps, watchdog never trips
		write_reg(REG_ACCEL, 32'd1);
		write_reg(REG_DECEL, 32'd1);
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		run_random(150);
		settle();

		// zero steps stall the ramp both ways
		write_reg(REG_ACCEL, 32'd0);
		write_reg(REG_DECEL, 32'd0);
		write_reg(REG_TIMEOUT, $urandom_range(0, 100));
		run_random(60);
		settle();

		// random mid-range setting
		write_reg(REG_ACCEL, $urandom_range(1, 255));
		write_reg(REG_DECEL, $urandom_range(1, 255));
		write_reg(REG_TIMEOUT, $urandom_range(0, 100));
		run_random(240);
		settle();

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== drive_command_ramp_controller.f =====
hw/rtl/drc_pkg.sv
hw/rtl/drc_cfg_regs.sv
hw/rtl/drc_core.sv
hw/rtl/drive_command_ramp_controller.sv
tb/testbench.sv
